@@ hw/rtl/adv_data_uuid_filter_top_defines.svh @@
// Assertion macros used by the RTL top.
`ifndef ADV_DATA_UUID_FILTER_TOP_DEFINES_SVH
`define ADV_DATA_UUID_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ADUF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADUF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/aduf_pkg.sv @@
package aduf_pkg;

  // AD types that list service UUIDs (incomplete / complete)
  localparam logic [7:0] AD_UUID16_INCOMPLETE  = 8'h02;
  localparam logic [7:0] AD_UUID16_COMPLETE    = 8'h03;
  localparam logic [7:0] AD_UUID128_INCOMPLETE = 8'h06;
  localparam logic [7:0] AD_UUID128_COMPLETE   = 8'h07;

  localparam logic [4:0] SHORT_UUID_BYTES = 5'd2;
  localparam logic [4:0] LONG_UUID_BYTES  = 5'd16;

  // Default target: 16-bit UUID 0x1809, bytes 0x09 then 0x18
  localparam logic [63:0] UUID_LOW_RESET = 64'h0000_0000_0000_1809;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 64;

  typedef enum logic [1:0] {
    REG_UUID_LONG = 2'd0,
    REG_UUID_LOW  = 2'd1,
    REG_UUID_HIGH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        uuid_long;
    logic [63:0] uuid_low;
    logic [63:0] uuid_high;
  } cfg_t;

endpackage

@@ hw/rtl/aduf_if.sv @@
interface aduf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aduf_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

@@ hw/rtl/adv_data_uuid_filter_top.sv @@
// Advertising-data service UUID filter. Payload bytes arrive one per
// transaction on in_ch with last_byte marking the final byte of a packet.
// The block walks the length/type/body structures; for a structure whose
// type lists service UUIDs (0x02/0x03 in 16-bit mode, 0x06/0x07 in 128-bit
// mode) the first UUID of the body is compared byte by byte with the target
// in uuid_low/uuid_high. A match counts only if all 2 or 16 UUID bytes lie
// inside the structure and the packet. Exactly one transaction leaves on
// out_ch per packet, on its last byte, carrying found. Throughput is one
// byte per clock: the parse state is updated by one small stage per byte,
// and the result sits in an output register in the cycle after the last byte
// is taken, so a stalled result only holds off input while it is still
// pending and out_ch.ready is low. Registers (64-bit APB, byte address
// 8*index): 0 uuid_long, 1 uuid_low (first target byte in bits 7:0),
// 2 uuid_high. Write registers only while no packet is in flight.
module adv_data_uuid_filter_top
  import aduf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  aduf_in_if.sink           in_ch,
  aduf_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg;

  aduf_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // Parse state
  logic [7:0] bytes_left_r, bytes_left_nxt;   // 0: next byte is a length byte
  logic       at_type_r, at_type_nxt;
  logic       listed_r, listed_nxt;
  logic [4:0] cmp_pos_r, cmp_pos_nxt;
  logic       equal_r, equal_nxt;
  logic       match_r, match_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic       found_r, found_nxt;

  logic         in_acc;
  logic [4:0]   ulen;
  logic [127:0] target;
  logic [7:0]   tgt_byte;
  logic         cmp_active;
  logic [4:0]   pos_inc;
  logic         eq_upd;

  // Input is taken whenever the result slot is free or draining this cycle.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.found = found_r;

  assign ulen       = cfg.uuid_long ? LONG_UUID_BYTES : SHORT_UUID_BYTES;
  assign target     = {cfg.uuid_high, cfg.uuid_low};
  assign tgt_byte   = target[{cmp_pos_r[3:0], 3'b000} +: 8];
  // mode may change under a running compare; past the length means no compare
  assign cmp_active = listed_r && (cmp_pos_r < ulen);
  assign pos_inc    = cmp_pos_r + 5'd1;
  assign eq_upd     = equal_r && (in_ch.data_byte == tgt_byte);

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    at_type_nxt    = at_type_r;
    listed_nxt     = listed_r;
    cmp_pos_nxt    = cmp_pos_r;
    equal_nxt      = equal_r;
    match_nxt      = match_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    found_nxt      = found_r;

    if (in_acc) begin
      if (bytes_left_r == 8'd0) begin
        // length byte; zero length is an empty structure
        if (in_ch.data_byte != 8'd0) begin
          bytes_left_nxt = in_ch.data_byte;
          at_type_nxt    = 1'b1;
        end
      end else if (at_type_r) begin
        bytes_left_nxt = bytes_left_r - 8'd1;
        at_type_nxt    = 1'b0;
        if (cfg.uuid_long) begin
          listed_nxt = (in_ch.data_byte == AD_UUID128_INCOMPLETE) ||
                       (in_ch.data_byte == AD_UUID128_COMPLETE);
        end else begin
          listed_nxt = (in_ch.data_byte == AD_UUID16_INCOMPLETE) ||
                       (in_ch.data_byte == AD_UUID16_COMPLETE);
        end
        cmp_pos_nxt = 5'd0;
        equal_nxt   = 1'b1;
      end else begin
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (cmp_active) begin
          equal_nxt   = eq_upd;
          cmp_pos_nxt = pos_inc;
          if ((pos_inc == ulen) && eq_upd) begin
            match_nxt = 1'b1;
          end
        end
      end

      if (in_ch.last_byte) begin
        out_valid_nxt  = 1'b1;
        found_nxt      = match_nxt;
        bytes_left_nxt = 8'd0;
        at_type_nxt    = 1'b0;
        listed_nxt     = 1'b0;
        cmp_pos_nxt    = 5'd0;
        equal_nxt      = 1'b0;
        match_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
      at_type_r    <= 1'b0;
      listed_r     <= 1'b0;
      cmp_pos_r    <= 5'd0;
      equal_r      <= 1'b0;
      match_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      at_type_r    <= at_type_nxt;
      listed_r     <= listed_nxt;
      cmp_pos_r    <= cmp_pos_nxt;
      equal_r      <= equal_nxt;
      match_r      <= match_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // found needs no reset; it is only looked at with out_valid_r
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
  end

`include "adv_data_uuid_filter_top_defines.svh"

  `ADUF_ASSERT_NOW(a_cmp_pos_range, 1'b1, cmp_pos_r <= LONG_UUID_BYTES, "compare position past 16")
  `ADUF_ASSERT_NEXT(a_last_gives_result, in_acc && in_ch.last_byte, out_valid_r, "no result after last byte")
  `ADUF_ASSERT_NEXT(a_last_clears, in_acc && in_ch.last_byte, (bytes_left_r == 8'd0) && !match_r && !at_type_r, "packet state not cleared")
  `ADUF_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_ch.ready, !in_ch.ready, "input taken while result stalled")

endmodule

@@ hw/rtl/aduf_cfg_regs.sv @@
module aduf_cfg_regs
  import aduf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[4:3]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_UUID_LONG: cfg_nxt.uuid_long = cfg_pwdata[0];
        REG_UUID_LOW:  cfg_nxt.uuid_low  = cfg_pwdata;
        REG_UUID_HIGH: cfg_nxt.uuid_high = cfg_pwdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UUID_LONG: cfg_prdata = {63'd0, cfg_r.uuid_long};
      REG_UUID_LOW:  cfg_prdata = cfg_r.uuid_low;
      REG_UUID_HIGH: cfg_prdata = cfg_r.uuid_high;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.uuid_long <= 1'b0;
      cfg_r.uuid_low  <= UUID_LOW_RESET;
      cfg_r.uuid_high <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
